FILE: rtl/core/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types, codes and the paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
package pngu_pkg;

  // filter codes as held per row; any code above 4 is folded to FILT_BAD
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam logic [2:0] FILT_BAD   = 3'd7;

  // configuration register indexes
  localparam logic REG_BPP       = 1'b0;
  localparam logic REG_ROW_BYTES = 1'b1;

  // one data beat waiting on its row store read
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] filt;
    logic       first;    // image's first row: up byte is zero
    logic       left_ok;  // byte position in row >= bytes per pixel: left bytes are real
    logic       last;
  } beat_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic signed [9:0] ta;
    logic signed [9:0] tb;
    logic signed [9:0] tc;
    // pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
    ta = $signed({2'b00, b}) - $signed({2'b00, c});
    tb = $signed({2'b00, a}) - $signed({2'b00, c});
    tc = ta + tb;
    pa = (ta < 0) ? -ta : ta;
    pb = (tb < 0) ? -tb : tb;
    pc = (tc < 0) ? -tc : tc;
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

endpackage

FILE: rtl/core/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction (method 0) on the inflated byte stream.
// ----------------------------------------------------------------------------
// Takes one inflated byte per beat and sustains one beat per cycle while
// m_tready is high. The first beat of each row carries the filter code and
// yields no output; each following beat yields one reconstructed byte (row
// store read, then output register), with m_tlast on the row's final byte
// and m_tuser set on every byte of a row whose filter code was above 4 (those
// bytes pass through unchanged). s_tuser marks the filter beat of an image's
// first row; the up byte reads as zero on that row, so the row store needs
// no clearing pass after reset and the block is ready at once. The rate is
// set by the row store: one read at acceptance, one write as the byte leaves
// the reconstruction stage. Configure bytes_per_pixel (1..8) and
// row_bytes (bytes per row, filter byte not counted) while the stream idles.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [14:0] cfg_wdata,
  // inflated stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tuser,    // [0] image_start
  // reconstructed stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] pixel_byte
  output logic        m_tlast,
  output logic        m_tuser     // [0] bad_filter
);

  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CW = $clog2(MAX_ROW_BYTES + 1);
  localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // config registers
  logic [3:0]  bpp;
  logic [14:0] row_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp       <= 4'd1;
      row_bytes <= 15'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        pngu_pkg::REG_BPP:       bpp       <= cfg_wdata[3:0];
        pngu_pkg::REG_ROW_BYTES: row_bytes <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp registers into range
  logic [3:0]    bpp_eff;
  logic [3:0]    bpp_m1;
  logic [PW-1:0] tap;
  logic [31:0]   rb_wide;
  logic [CW-1:0] rb_eff;

  always_comb begin
    if (bpp == 4'd0) begin
      bpp_eff = 4'd1;
    end else if (bpp > 4'(MAX_PIXEL_BYTES)) begin
      bpp_eff = 4'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp;
    end
    rb_wide = {17'd0, row_bytes};
    if (rb_wide == 32'd0) begin
      rb_eff = CW'(1);
    end else if (rb_wide > 32'(MAX_ROW_BYTES)) begin
      rb_eff = CW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = rb_wide[CW-1:0];
    end
  end

  assign bpp_m1 = bpp_eff - 4'd1;
  assign tap    = bpp_m1[PW-1:0];

  // row control: column is 0 while a filter beat is due, else 1 + position
  logic [CW-1:0] column;
  logic [CW-1:0] col_m1;
  logic [2:0]    row_filter;
  logic          on_first_row;
  logic          in_acc;
  logic          is_filt;
  logic          load;
  logic [AW-1:0] x;
  logic          at_last;
  logic          left_ok;

  // reconstruction stage
  pngu_pkg::beat_t s1;
  logic            s1_valid;
  logic [AW-1:0]   s1_x;
  logic            s1_adv;
  logic            fire;
  logic [7:0]      up_raw;
  logic [7:0]      pixel;
  logic [7:0]      up_byte;

  assign s1_adv   = !m_tvalid || m_tready;
  assign fire     = s1_valid && s1_adv;
  assign s_tready = !s1_valid || s1_adv;
  assign in_acc   = s_tvalid && s_tready;
  assign is_filt  = s_tuser || (column == '0);
  assign load     = in_acc && !is_filt;
  assign col_m1   = column - CW'(1);
  assign x        = col_m1[AW-1:0];
  assign at_last  = (column >= rb_eff);
  assign left_ok  = (32'(x) >= 32'(bpp_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      row_filter   <= pngu_pkg::FILT_NONE;
      on_first_row <= 1'b1;
    end else if (in_acc) begin
      if (is_filt) begin
        // filter beat; image start also abandons any unfinished row
        if (s_tuser) begin
          on_first_row <= 1'b1;
        end
        row_filter <= (s_tdata > 8'd4) ? pngu_pkg::FILT_BAD : s_tdata[2:0];
        column     <= CW'(1);
      end else if (at_last) begin
        column       <= '0;
        on_first_row <= 1'b0;
      end else begin
        column <= column + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1.data    <= s_tdata;
      s1.filt    <= row_filter;
      s1.first   <= on_first_row;
      s1.left_ok <= left_ok;
      s1.last    <= at_last;
      s1_x       <= x;
    end
  end

  // Read at acceptance, write back as the beat leaves. Same-address overlap
  // cannot happen: consecutive beats of a row differ in column, and a filter
  // beat always parts two rows. That filter beat is taken no earlier than the
  // edge at which the row's last byte leaves and is written, so the next
  // row's reads see the fresh bytes.
  pngu_row_mem #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (load),
    .rd_addr (x),
    .rd_data (up_raw),
    .wr_en   (fire),
    .wr_addr (s1_x),
    .wr_data (pixel)
  );

  pngu_recon #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .PW              (PW)
  ) u_recon (
    .clk     (clk),
    .beat    (s1),
    .up_raw  (up_raw),
    .tap     (tap),
    .fire    (fire),
    .pixel   (pixel),
    .up_byte (up_byte)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= pixel;
      m_tlast <= s1.last;
      m_tuser <= (s1.filt == pngu_pkg::FILT_BAD);
    end
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (load && fire) |-> (x != s1_x))
    else $error("row store read and write hit the same entry");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !in_acc)
    else $error("beat accepted while reconstruction stage is stalled");

  a_last_closes_row: assert property (@(posedge clk) disable iff (rst)
    (load && at_last) |=> (column == '0))
    else $error("row did not close after its last byte");

  a_first_row_up_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.first) |-> (up_byte == 8'd0))
    else $error("up byte nonzero on first row");
`endif

endmodule

FILE: rtl/core/pngu_row_mem.sv
// ----------------------------------------------------------------------------
// pngu_row_mem
// Prior-row byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pngu_row_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/pngu_recon.sv
// ----------------------------------------------------------------------------
// pngu_recon
// Byte reconstruction: left and upper-left history and the five filters.
// ----------------------------------------------------------------------------
module pngu_recon #(
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int PW              = 3
) (
  input  logic                clk,
  input  pngu_pkg::beat_t     beat,
  input  logic [7:0]          up_raw,   // row store read data
  input  logic [PW-1:0]       tap,      // bytes per pixel minus one
  input  logic                fire,     // beat leaves the stage
  output logic [7:0]          pixel,
  output logic [7:0]          up_byte
);

  logic [7:0] left [MAX_PIXEL_BYTES];
  logic [7:0] upl  [MAX_PIXEL_BYTES];
  logic [7:0] a;
  logic [7:0] c;
  logic [8:0] avg_sum;

  // history older than the row start is gated off rather than cleared
  assign a       = beat.left_ok ? left[tap] : 8'd0;
  assign c       = beat.left_ok ? upl[tap]  : 8'd0;
  assign up_byte = beat.first ? 8'd0 : up_raw;
  assign avg_sum = {1'b0, a} + {1'b0, up_byte};

  always_comb begin
    case (beat.filt)
      pngu_pkg::FILT_NONE:  pixel = beat.data;
      pngu_pkg::FILT_SUB:   pixel = beat.data + a;
      pngu_pkg::FILT_UP:    pixel = beat.data + up_byte;
      pngu_pkg::FILT_AVG:   pixel = beat.data + avg_sum[8:1];
      pngu_pkg::FILT_PAETH: pixel = beat.data + pngu_pkg::paeth(a, up_byte, c);
      default:              pixel = beat.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      left[0] <= pixel;
      upl[0]  <= up_byte;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left[i] <= left[i-1];
        upl[i]  <= upl[i-1];
      end
    end
  end

endmodule
